FILE: hw/rtl/llap_rd_pkg.sv
// Shared types, codes and the CRC step function of the receive deframer.
package llap_rd_pkg;

    // Default largest number of bytes that one frame may hold.
    localparam int unsigned MAX_FRAME_BYTES_DEF = 1024;

    // Widths of the fields that travel on the channels.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned STATUS_W = 4;

    // Escape codes on the serial link.
    localparam logic [BYTE_W-1:0] ESC_MARK    = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_LITERAL = 8'hFF;
    localparam logic [BYTE_W-1:0] ESC_END     = 8'hFD;
    localparam logic [BYTE_W-1:0] ESC_FRAME   = 8'hFE;
    localparam logic [BYTE_W-1:0] ESC_ABORT   = 8'hFA;
    localparam logic [BYTE_W-1:0] ESC_DEV_CRC = 8'hFC;

    // Control frame types.
    localparam logic [BYTE_W-1:0] CODE_ENQ = 8'h81;
    localparam logic [BYTE_W-1:0] CODE_ACK = 8'h82;
    localparam logic [BYTE_W-1:0] CODE_CTS = 8'h85;

    // CRC start value and the residue of a frame that checks good.
    localparam logic [CRC_W-1:0] CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_RESIDUE = 16'hF0B8;

    // A control frame holds exactly this many bytes.
    localparam int unsigned CTRL_FRAME_BYTES = 5;

    // Register byte addresses on the configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_NODE_ADDRESS     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_AWAITING_ADDRESS = 3'd4;

    // End-of-frame status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD         = 4'd0,
        ST_BAD_CRC      = 4'd1,
        ST_SHORT        = 4'd2,
        ST_ENQ_REPLY    = 4'd3,
        ST_ACK_SEEN     = 4'd4,
        ST_CTRL_IGNORED = 4'd5,
        ST_FRAME_ERR    = 4'd6,
        ST_ABORT        = 4'd7,
        ST_DEV_CRC      = 4'd8,
        ST_UNKNOWN      = 4'd9,
        ST_OVERFLOW     = 4'd10
    } frame_status_t;

    // One byte step of the reflected CRC-CCITT.
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] d;
        logic [CRC_W-1:0]  wide;
        d    = data ^ crc[7:0];
        d    = d ^ (d << 4);
        wide = {8'h00, d};
        return {d, crc[15:8]} ^ (wide >> 4) ^ (wide << 3);
    endfunction

endpackage

FILE: hw/rtl/llap_rd_byte_if.sv
// Channel that carries one received link byte per item.
interface llap_rd_byte_if
    import llap_rd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/llap_rd_result_if.sv
// Channel that carries one data byte or end-of-frame status per item.
interface llap_rd_result_if
    import llap_rd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                is_status;
    logic [BYTE_W-1:0]   data_byte;
    logic [STATUS_W-1:0] frame_status;
    logic [LEN_W-1:0]    frame_length;
    logic [BYTE_W-1:0]   reply_destination;

    modport source (output valid, output is_status, output data_byte, output frame_status,
                    output frame_length, output reply_destination, input ready);
    modport sink (input valid, input is_status, input data_byte, input frame_status,
                  input frame_length, input reply_destination, output ready);
endinterface

FILE: hw/rtl/llap_receive_deframer.sv
// Receive deframer: unescapes link bytes, checks the CRC and reports frame status.
//
// The block takes one raw link byte per item and returns at most one item for it:
// a data byte, or a status at the end of a frame. A byte is captured in an input
// register, processed against the frame state and lands in a result register;
// a new byte can be taken in every cycle while the result side keeps up. The rate
// is set by the frame state update (escape, CRC, count). Bytes past MAX_FRAME_BYTES
// are dropped and the frame then ends with the overflow status.
// node_address sits at byte address 0 and awaiting_address at address 4; write
// them only while no item is in flight.
module llap_receive_deframer
    import llap_rd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    llap_rd_byte_if.sink          rx,
    llap_rd_result_if.source      res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_CTRL = CNT_W'(CTRL_FRAME_BYTES);

    // Configuration registers.
    logic [BYTE_W-1:0] node_address_reg;
    logic              awaiting_address_reg;
    logic              cfg_write;

    // Input stage.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;

    // Frame state.
    logic              escape_pending_reg, escape_pending_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [CRC_W-1:0]  running_crc_reg, running_crc_next;
    logic [BYTE_W-1:0] source_field_reg, source_field_next;
    logic [BYTE_W-1:0] type_field_reg, type_field_next;
    logic              overflowed_reg, overflowed_next;

    // Result register.
    logic                res_valid_reg;
    logic                res_is_status_reg, res_is_status_next;
    logic [BYTE_W-1:0]   res_data_reg, res_data_next;
    frame_status_t       res_status_reg, res_status_next;
    logic [LEN_W-1:0]    res_length_reg, res_length_next;
    logic [BYTE_W-1:0]   res_dest_reg, res_dest_next;
    logic                emit;

    // Configuration port: always ready, written on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg     <= '0;
            awaiting_address_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ADDR_NODE_ADDRESS[2])
                node_address_reg <= pwdata[BYTE_W-1:0];
            else
                awaiting_address_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        if (paddr[2] == ADDR_AWAITING_ADDRESS[2])
            prdata = {31'd0, awaiting_address_reg};
        else
            prdata = {24'd0, node_address_reg};
    end

    // The input stage moves on once the result register is free or being emptied.
    assign advance  = in_valid_reg && (!res_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
    end

    // Escape handling, CRC and classification of the byte in the input stage.
    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        byte_count_next     = byte_count_reg;
        running_crc_next    = running_crc_reg;
        source_field_next   = source_field_reg;
        type_field_next     = type_field_reg;
        overflowed_next     = overflowed_reg;
        emit                = 1'b0;
        res_is_status_next  = 1'b0;
        res_data_next       = '0;
        res_status_next     = ST_GOOD;
        res_length_next     = '0;
        res_dest_next       = '0;

        if (in_byte_reg == ESC_MARK)
        begin
            escape_pending_next = 1'b1;
        end
        else if (!escape_pending_reg || in_byte_reg == ESC_LITERAL)
        begin
            // A data byte; an escaped literal stands for a zero byte.
            escape_pending_next = 1'b0;
            if (byte_count_reg >= CNT_MAX)
            begin
                overflowed_next = 1'b1;
            end
            else
            begin
                res_data_next    = escape_pending_reg ? ESC_MARK : in_byte_reg;
                running_crc_next = crc_step(running_crc_reg, res_data_next);
                if (byte_count_reg == CNT_W'(1))
                    source_field_next = res_data_next;
                else if (byte_count_reg == CNT_W'(2))
                    type_field_next = res_data_next;
                byte_count_next = byte_count_reg + CNT_W'(1);
                res_length_next = LEN_W'(byte_count_next);
                emit            = 1'b1;
            end
        end
        else
        begin
            // End of frame: report and go back to the idle frame state.
            emit               = 1'b1;
            res_is_status_next = 1'b1;
            res_length_next    = LEN_W'(byte_count_reg);
            if (overflowed_reg)
            begin
                res_status_next = ST_OVERFLOW;
            end
            else
            begin
                case (in_byte_reg)
                    ESC_END:
                    begin
                        if (byte_count_reg == CNT_CTRL &&
                            type_field_reg inside {[CODE_ENQ:CODE_CTS]})
                        begin
                            if (type_field_reg == CODE_ENQ && node_address_reg != '0 &&
                                source_field_reg == node_address_reg)
                            begin
                                res_status_next = ST_ENQ_REPLY;
                                res_dest_next   = source_field_reg;
                            end
                            else if (type_field_reg == CODE_ACK && awaiting_address_reg)
                                res_status_next = ST_ACK_SEEN;
                            else
                                res_status_next = ST_CTRL_IGNORED;
                        end
                        else if (byte_count_reg <= CNT_CTRL)
                            res_status_next = ST_SHORT;
                        else if (running_crc_reg == CRC_RESIDUE)
                            res_status_next = ST_GOOD;
                        else
                            res_status_next = ST_BAD_CRC;
                    end
                    ESC_FRAME:   res_status_next = ST_FRAME_ERR;
                    ESC_ABORT:   res_status_next = ST_ABORT;
                    ESC_DEV_CRC: res_status_next = ST_DEV_CRC;
                    default:     res_status_next = ST_UNKNOWN;
                endcase
            end
            escape_pending_next = 1'b0;
            byte_count_next     = '0;
            running_crc_next    = CRC_INIT;
            source_field_next   = '0;
            type_field_next     = '0;
            overflowed_next     = 1'b0;
        end
    end

    // Frame state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            byte_count_reg     <= '0;
            running_crc_reg    <= CRC_INIT;
            source_field_reg   <= '0;
            type_field_reg     <= '0;
            overflowed_reg     <= 1'b0;
        end
        else if (advance)
        begin
            escape_pending_reg <= escape_pending_next;
            byte_count_reg     <= byte_count_next;
            running_crc_reg    <= running_crc_next;
            source_field_reg   <= source_field_next;
            type_field_reg     <= type_field_next;
            overflowed_reg     <= overflowed_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= emit;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_is_status_reg <= res_is_status_next;
            res_data_reg      <= res_data_next;
            res_status_reg    <= res_status_next;
            res_length_reg    <= res_length_next;
            res_dest_reg      <= res_dest_next;
        end
    end

    assign res.valid             = res_valid_reg;
    assign res.is_status         = res_is_status_reg;
    assign res.data_byte         = res_data_reg;
    assign res.frame_status      = res_status_reg;
    assign res.frame_length      = res_length_reg;
    assign res.reply_destination = res_dest_reg;

    // The byte count never runs past the frame limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_MAX)
    else $error("byte count beyond frame limit");

    // Overflow is only ever flagged on a full frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> byte_count_reg == CNT_MAX)
    else $error("overflow flagged on a frame that is not full");

    // A status item leaves the frame state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit && res_is_status_next |=>
            byte_count_reg == '0 && running_crc_reg == CRC_INIT && !escape_pending_reg)
    else $error("frame state not cleared after frame end");

    // A zero byte arms the escape and gives no item.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_byte_reg == ESC_MARK |=> escape_pending_reg && !res_valid_reg)
    else $error("escape byte handled wrongly");

endmodule

FILE: test/llap_rd_frame_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the deframer's results from the link bytes and compares them.
module llap_rd_frame_checker
    import llap_rd_pkg::*;
#(
    parameter int unsigned MAX_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    llap_rd_byte_if               rx,
    llap_rd_result_if             res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending_count,
    output logic [15:0]           statuses_seen
);

    // One deframed item: a data byte or an end-of-frame status.
    typedef struct {
        logic                is_status;
        logic [BYTE_W-1:0]   data_byte;
        frame_status_t       status;
        logic [LEN_W-1:0]    length;
        logic [BYTE_W-1:0]   dest;
    } deframed_t;

    deframed_t expected_q[$];
    int        mismatches;

    // Frame state as the block should hold it.
    bit                esc_armed;
    int unsigned       frame_bytes;
    logic [CRC_W-1:0]  fcs_acc;
    logic [BYTE_W-1:0] src_seen;
    logic [BYTE_W-1:0] type_seen;
    bit                frame_overflow;

    // Our copy of the configuration registers.
    logic [BYTE_W-1:0] node_cfg;
    bit                await_cfg;

    // Reflected CRC-CCITT, one bit at a time with the reversed polynomial.
    function automatic logic [CRC_W-1:0] fcs_update(input logic [CRC_W-1:0] c,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            x = x[0] ? ((x >> 1) ^ 16'h8408) : (x >> 1);
        return x;
    endfunction

    function automatic void clear_frame_state();
        esc_armed      = 1'b0;
        frame_bytes    = 0;
        fcs_acc        = CRC_INIT;
        src_seen       = '0;
        type_seen      = '0;
        frame_overflow = 1'b0;
    endfunction

    // Status of a frame closed by the end code.
    function automatic frame_status_t classify_end();
        if (frame_bytes == CTRL_FRAME_BYTES && type_seen >= CODE_ENQ && type_seen <= CODE_CTS)
        begin
            if (type_seen == CODE_ENQ && node_cfg != 0 && src_seen == node_cfg)
                return ST_ENQ_REPLY;
            if (type_seen == CODE_ACK && await_cfg)
                return ST_ACK_SEEN;
            return ST_CTRL_IGNORED;
        end
        if (frame_bytes <= CTRL_FRAME_BYTES)
            return ST_SHORT;
        return (fcs_acc == CRC_RESIDUE) ? ST_GOOD : ST_BAD_CRC;
    endfunction

    // Advances the frame state by one link byte; returns 1 when an item is due.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output deframed_t r);
        logic [BYTE_W-1:0] data;
        r.is_status = 1'b0;
        r.data_byte = '0;
        r.status    = ST_GOOD;
        r.length    = '0;
        r.dest      = '0;
        if (b == ESC_MARK) begin
            esc_armed = 1'b1;
            return 1'b0;
        end
        if (esc_armed) begin
            esc_armed = 1'b0;
            if (b != ESC_LITERAL) begin
                r.is_status = 1'b1;
                if (frame_overflow)
                    r.status = ST_OVERFLOW;
                else if (b == ESC_END)
                    r.status = classify_end();
                else if (b == ESC_FRAME)
                    r.status = ST_FRAME_ERR;
                else if (b == ESC_ABORT)
                    r.status = ST_ABORT;
                else if (b == ESC_DEV_CRC)
                    r.status = ST_DEV_CRC;
                else
                    r.status = ST_UNKNOWN;
                if (r.status == ST_ENQ_REPLY)
                    r.dest = src_seen;
                r.length = frame_bytes[LEN_W-1:0];
                clear_frame_state();
                return 1'b1;
            end
            data = 8'h00;
        end else begin
            data = b;
        end
        // A full frame drops further bytes and remembers that it did.
        if (frame_bytes >= MAX_BYTES) begin
            frame_overflow = 1'b1;
            return 1'b0;
        end
        fcs_acc = fcs_update(fcs_acc, data);
        if (frame_bytes == 1)
            src_seen = data;
        else if (frame_bytes == 2)
            type_seen = data;
        frame_bytes++;
        r.data_byte = data;
        r.length    = frame_bytes[LEN_W-1:0];
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Results are compared before the same edge's input is predicted: a result
    // never belongs to a byte taken at the same edge.
    always @(posedge clk or negedge rst_n) begin : watch
        deframed_t want;
        if (!rst_n) begin
            clear_frame_state();
            node_cfg = '0;
            await_cfg = 1'b0;
            expected_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending_count <= 0;
            statuses_seen <= '0;
        end else begin
            if (res.valid && res.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: item with none expected, status flag %0b, byte %0h",
                             $time, res.is_status, res.data_byte);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("is_status", 16'(want.is_status), 16'(res.is_status));
                    check_field("data_byte", 16'(want.data_byte), 16'(res.data_byte));
                    check_field("frame_status", 16'(want.status), 16'(res.frame_status));
                    check_field("frame_length", 16'(want.length), 16'(res.frame_length));
                    check_field("reply_destination", 16'(want.dest),
                                16'(res.reply_destination));
                end
                if (res.is_status)
                    statuses_seen[res.frame_status] <= 1'b1;
            end
            if (rx.valid && rx.ready) begin
                if (deframe_byte(rx.rx_byte, want))
                    expected_q.push_back(want);
            end
            // Register writes land at the access edge.
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_NODE_ADDRESS)
                    node_cfg = pwdata[BYTE_W-1:0];
                else if (paddr == ADDR_AWAITING_ADDRESS)
                    await_cfg = pwdata[0];
            end
            fail_count <= mismatches;
            pending_count <= expected_q.size();
        end
    end

endmodule

FILE: test/llap_receive_deframer_tb.sv
`timescale 1ns / 100ps
// Top of the deframer testbench: link byte stimulus, register writes and the verdict.
module llap_receive_deframer_tb;
    import llap_rd_pkg::*;

    localparam int unsigned FRAME_LIMIT  = MAX_FRAME_BYTES_DEF;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          PHASE_BYTES  = 35;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int          fail_count;
    int          pending_count;
    logic [15:0] statuses_seen;

    bit                send_gaps     = 1'b1;
    bit                result_stalls = 1'b1;
    bit                hold_request  = 1'b0;
    logic [BYTE_W-1:0] node_now      = '0;
    logic              await_now     = 1'b0;
    int                bytes_sent    = 0;
    int                frames_sent   = 0;

    llap_rd_byte_if   rx_if ();
    llap_rd_result_if res_if ();

    llap_receive_deframer #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    llap_rd_frame_checker #(
        .MAX_BYTES(FRAME_LIMIT)
    ) u_frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_if),
        .res           (res_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .statuses_seen (statuses_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, or one long hold-off when the sender asks.
    initial begin
        int held;
        res_if.ready <= 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                res_if.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_request = 1'b0;
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= !(result_stalls && $urandom_range(99) < 35);
            end
        end
    end

    // Generator side of the frame check sequence.
    function automatic logic [CRC_W-1:0] fcs_update(input logic [CRC_W-1:0] c,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            x = x[0] ? ((x >> 1) ^ 16'h8408) : (x >> 1);
        return x;
    endfunction

    // Payload bytes lean towards the codes that need escaping or look like them.
    function automatic logic [BYTE_W-1:0] pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return ESC_MARK;
        if (r < 13)
            return ESC_LITERAL;
        if (r < 16)
            return ESC_END;
        return 8'($urandom_range(255));
    endfunction

    task automatic random_body(ref logic [BYTE_W-1:0] body[$], input int n);
        for (int k = 0; k < n; k++)
            body.push_back(pick_payload());
    endtask

    // Offers one raw link byte and waits until it is taken.
    task automatic put_raw(input logic [BYTE_W-1:0] b);
        while (send_gaps && $urandom_range(99) < 35) begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // A zero data byte goes on the link as the escape mark and the literal code.
    task automatic put_data(input logic [BYTE_W-1:0] b);
        if (b == ESC_MARK) begin
            put_raw(ESC_MARK);
            put_raw(ESC_LITERAL);
        end else begin
            put_raw(b);
        end
    endtask

    task automatic end_frame(input logic [BYTE_W-1:0] code);
        put_raw(ESC_MARK);
        put_raw(code);
    endtask

    task automatic send_frame(ref logic [BYTE_W-1:0] body[$], input bit with_fcs,
                              input bit spoil, input logic [BYTE_W-1:0] code);
        logic [CRC_W-1:0] fcs;
        fcs = CRC_INIT;
        foreach (body[k]) begin
            fcs = fcs_update(fcs, body[k]);
            put_data(body[k]);
        end
        if (with_fcs) begin
            fcs = ~fcs;
            if (spoil)
                fcs = fcs ^ (16'h0001 << $urandom_range(15));
            put_data(fcs[7:0]);
            put_data(fcs[15:8]);
        end
        end_frame(code);
        frames_sent++;
    endtask

    // One frame of a randomly chosen kind; most are well formed.
    task automatic send_random_frame();
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] kind_type;
        logic [BYTE_W-1:0] code;
        int                r;
        int                n;
        r = $urandom_range(99);
        if (r < 55) begin
            // Data frame, good or with a damaged check sequence.
            random_body(body, 3 + $urandom_range(24));
            send_frame(body, 1'b1, r >= 40, ESC_END);
        end else if (r < 75) begin
            // Control frame, now and then one byte too long or too short.
            case ($urandom_range(6))
                0: kind_type = CODE_ENQ;
                1: kind_type = CODE_ACK;
                2: kind_type = CODE_CTS;
                3: kind_type = CODE_ENQ - 8'd1;
                4: kind_type = CODE_CTS + 8'd1;
                default: kind_type = 8'($urandom_range(CODE_ENQ, CODE_CTS));
            endcase
            body.push_back(8'($urandom_range(255)));
            body.push_back($urandom_range(1) ? node_now : 8'($urandom_range(255)));
            body.push_back(kind_type);
            n = $urandom_range(9);
            if (n == 0)
                body.push_back(pick_payload());
            else if (n == 1)
                void'(body.pop_front());
            send_frame(body, 1'b1, $urandom_range(3) == 0, ESC_END);
        end else if (r < 85) begin
            random_body(body, $urandom_range(5));
            send_frame(body, 1'b0, 1'b0, ESC_END);
        end else if (r < 93) begin
            // Frame closed by a device report or an unknown code.
            case ($urandom_range(3))
                0: code = ESC_FRAME;
                1: code = ESC_ABORT;
                2: code = ESC_DEV_CRC;
                default: code = 8'($urandom_range(1, 254));
            endcase
            random_body(body, $urandom_range(10));
            send_frame(body, 1'($urandom_range(1)), 1'b0, code);
        end else begin
            // Line noise, which may leave an escape armed or a frame open.
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                put_raw(8'($urandom_range(255)));
        end
    endtask

    // Stops sending and waits until every expected item is back and the pipe is empty.
    task automatic drain_results();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial begin
        logic [BYTE_W-1:0] body[$];
        int                target;
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, literal zero, repeated escape marks and every end code.
        put_raw(8'h01);
        put_raw(8'hFF);
        put_data(8'h00);
        put_raw(ESC_MARK);
        put_raw(ESC_MARK);
        put_raw(ESC_MARK);
        put_raw(ESC_END);
        put_raw(8'h80);
        end_frame(ESC_FRAME);
        put_raw(8'h7F);
        end_frame(ESC_ABORT);
        end_frame(ESC_DEV_CRC);
        end_frame(8'h01);
        end_frame(8'hFE - 8'd1);
        end_frame(ESC_END);

        // Random frames under several register settings.
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: begin node_now = 8'h00; await_now = 1'b0; end
                1: begin node_now = 8'hFF; await_now = 1'b1; end
                2: begin node_now = 8'h01; await_now = 1'b0; end
                3: begin node_now = 8'($urandom_range(2, 254)); await_now = 1'b1; end
                4: begin node_now = 8'($urandom_range(1, 255)); await_now = 1'b0; end
                default: begin node_now = 8'h00; await_now = 1'b1; end
            endcase
            reg_write(ADDR_NODE_ADDRESS, {24'h0, node_now});
            reg_write(ADDR_AWAITING_ADDRESS, {31'h0, await_now});
            send_gaps     = (phase != 4);
            result_stalls = (phase != 4);
            if (phase == 2) begin
                // The result side holds off while a long frame keeps coming.
                hold_request = 1'b1;
                body = {};
                random_body(body, 30);
                send_frame(body, 1'b1, 1'b0, ESC_END);
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                send_random_frame();
        end

        // A frame that fills up exactly and then overflows; a literal zero past the
        // limit is dropped too, and the abort code still reports the overflow.
        drain_results();
        body = {};
        for (int k = 0; k < int'(FRAME_LIMIT); k++)
            body.push_back(8'($urandom_range(1, 255)));
        body.push_back(8'h00);
        send_frame(body, 1'b0, 1'b0, ESC_ABORT);

        drain_results();
        $display("Sent %0d link bytes in %0d frames under six register settings.",
                 bytes_sent, frames_sent);
        $display("Distinct end statuses returned: %0d of 11; mismatches: %0d.",
                 $countones(statuses_seen), fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/llap_rd_pkg.sv
hw/rtl/llap_rd_byte_if.sv
hw/rtl/llap_rd_result_if.sv
hw/rtl/llap_receive_deframer.sv
test/llap_rd_frame_checker.sv
test/llap_receive_deframer_tb.sv
